// ----- rtl/trial_division_prime_filter_unit_macros.svh -----
// Assertion macros shared by the prime filter checker.
`ifndef TRIAL_DIVISION_PRIME_FILTER_UNIT_MACROS_SVH
`define TRIAL_DIVISION_PRIME_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TDPF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TDPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tdpf_pkg.sv -----
// Shared constants and types of the trial division prime filter.
`timescale 1ns / 1ps
package tdpf_pkg;

	// Bits of the input value that take part in the test (at most the 16-bit field)
	localparam int VALUE_WIDTH = 16;
	// Divisor width: holds the first divisor whose square exceeds any value
	localparam int DIV_W       = (VALUE_WIDTH + 1) / 2 + 1;
	// Width of the running square of the divisor
	localparam int SQ_W        = 2 * DIV_W;
	// Bit counter of the serial remainder unit
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
	// Stream field widths
	localparam int FIELD_W     = 16;
	localparam int COUNT_W     = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Status of the serial remainder unit
	typedef struct packed {
		logic done;  // one-cycle pulse: remainder is complete
		logic zero;  // remainder was zero (valid with done)
	} rem_stat_t;

endpackage

// ----- rtl/tdpf_rem_serial.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module tdpf_rem_serial (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [tdpf_pkg::VALUE_WIDTH-1:0]    dividend,
	input  logic [tdpf_pkg::DIV_W-1:0]          divisor,
	output tdpf_pkg::rem_stat_t                 stat
);

	logic [tdpf_pkg::VALUE_WIDTH-1:0] sh_q;
	logic [tdpf_pkg::DIV_W-1:0]       div_q;
	logic [tdpf_pkg::DIV_W-1:0]       rem_q;
	logic [tdpf_pkg::BIT_CNT_W-1:0]   cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic                             zero_q;

	logic [tdpf_pkg::DIV_W:0]         trial;
	logic [tdpf_pkg::DIV_W:0]         diff;
	logic [tdpf_pkg::DIV_W-1:0]       rem_next;

	// Shift the next dividend bit into the partial remainder, subtract if it fits
	always_comb begin
		trial = {rem_q, sh_q[tdpf_pkg::VALUE_WIDTH-1]};
		diff  = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q}) begin
			rem_next = diff[tdpf_pkg::DIV_W-1:0];
		end else begin
			rem_next = trial[tdpf_pkg::DIV_W-1:0];
		end
	end

	// Sequence the bits and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tdpf_pkg::BIT_CNT_W'(tdpf_pkg::VALUE_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[tdpf_pkg::VALUE_WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
			if (cnt_q == '0) begin
				zero_q <= (rem_next == '0);
			end
		end
	end

	assign stat.done = done_q;
	assign stat.zero = zero_q;

endmodule

// ----- rtl/trial_division_prime_filter_unit.sv -----
// Top level of the trial division prime filter: sequencer, count and output register.
`timescale 1ns / 1ps
// Each value on the input stream is tested for primality by trial division with the
// divisors 2, 3, ... while the divisor squared does not exceed the value; 0 and 1 are not
// prime. One result comes out per input: the value and the running count of primes in the
// list (saturating at 65535, cleared after the item with tlast), with the prime flag on
// tuser and tlast copied. The remainder for each divisor is formed bit-serially, one value
// bit per cycle. One item is worked on at a time, and the next is taken while a finished
// result still waits in the output register.
module trial_division_prime_filter_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] value
	input  logic        s_tlast,   // last_item
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] value_out, [31:16] prime_count
	output logic        m_tuser,   // is_prime
	output logic        m_tlast    // last_item_out
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t                             state_q;
	logic [tdpf_pkg::VALUE_WIDTH-1:0]   n_q;
	logic                               last_q;
	logic                               prime_q;
	logic [tdpf_pkg::DIV_W-1:0]         d_q;
	logic [tdpf_pkg::SQ_W-1:0]          sq_q;
	logic [tdpf_pkg::COUNT_W-1:0]       cnt_q;

	logic                               m_tvalid_q;
	logic [tdpf_pkg::FIELD_W-1:0]       m_value_q;
	logic [tdpf_pkg::COUNT_W-1:0]       m_count_q;
	logic                               m_prime_q;
	logic                               m_last_q;

	logic                               in_xact;
	logic                               out_free;
	logic                               sq_over;
	logic                               rem_start;
	logic [tdpf_pkg::COUNT_W-1:0]       cnt_next;
	tdpf_pkg::rem_stat_t                rem_stat;

	assign in_xact   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign sq_over   = sq_q > tdpf_pkg::SQ_W'(n_q);
	assign rem_start = (state_q == ST_CHECK) && !sq_over;

	// Count including this item, saturating
	always_comb begin
		if (prime_q && (cnt_q != tdpf_pkg::COUNT_MAX)) begin
			cnt_next = cnt_q + 1'b1;
		end else begin
			cnt_next = cnt_q;
		end
	end

	// Clear the count after the last item of a list
	function automatic logic [tdpf_pkg::COUNT_W-1:0] s_last_clear(
		input logic                         last,
		input logic [tdpf_pkg::COUNT_W-1:0] cnt
	);
		s_last_clear = last ? '0 : cnt;
	endfunction

	tdpf_rem_serial u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (n_q),
		.divisor  (d_q),
		.stat     (rem_stat)
	);

	// Sequence the divisors and hand finished results to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// drop a taken result unless a new one loads in this cycle
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						if (s_tdata[tdpf_pkg::VALUE_WIDTH-1:0] < tdpf_pkg::VALUE_WIDTH'(2)) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (sq_over) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_stat.done) begin
						if (rem_stat.zero) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						cnt_q      <= s_last_clear(last_q, cnt_next);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working value, divisor, square and verdict
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xact) begin
					n_q     <= s_tdata[tdpf_pkg::VALUE_WIDTH-1:0];
					last_q  <= s_tlast;
					d_q     <= tdpf_pkg::DIV_W'(2);
					sq_q    <= tdpf_pkg::SQ_W'(4);
					prime_q <= 1'b0;
				end
			end
			ST_CHECK: begin
				if (sq_over) begin
					prime_q <= 1'b1;
				end
			end
			ST_DIV: begin
				if (rem_stat.done && !rem_stat.zero) begin
					// (d + 1)^2 = d^2 + 2d + 1
					sq_q <= sq_q + tdpf_pkg::SQ_W'({d_q, 1'b1});
					d_q  <= d_q + 1'b1;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					m_value_q <= tdpf_pkg::FIELD_W'(n_q);
					m_count_q <= cnt_next;
					m_prime_q <= prime_q;
					m_last_q  <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_count_q, m_value_q};
	assign m_tuser  = m_prime_q;
	assign m_tlast  = m_last_q;

endmodule

// ----- rtl/tdpf_checker.sv -----
// Port-level checker of the prime filter, bound to the top level.
`timescale 1ns / 1ps
`include "trial_division_prime_filter_unit_macros.svh"
module tdpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result holds its payload
	`TDPF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// After an input transaction the block is busy testing
	`TDPF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// A prime result always counts at least one prime
	`TDPF_ASSERT_IMPL(a_prime_counted, m_tvalid && m_tuser, m_tdata[31:16] != 16'd0, "prime with zero count")

	// The only even prime is two, and zero and one are never prime
	`TDPF_ASSERT_IMPL(a_prime_sane, m_tvalid && m_tuser, (m_tdata[0] && m_tdata[15:0] != 16'd1) || m_tdata[15:0] == 16'd2, "bad prime flag")

endmodule

bind trial_division_prime_filter_unit tdpf_checker u_tdpf_checker (.*);
